[rtl/fps_pkg.sv]
`timescale 1ns / 1ps

package fps_pkg;

  localparam int unsigned MAX_FRAMES = 64;

  localparam int unsigned FrameW = 6;
  localparam int unsigned DirW   = 2;
  localparam int unsigned StepW  = 7;
  localparam int unsigned MaskW  = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  // dividend of the try count reaches 63 + 127
  localparam int unsigned DivW   = 8;
  // candidate frame spans -127 .. 190
  localparam int unsigned TestW  = 9;

  typedef enum logic [1:0] {
    OP_ADVANCE    = 2'd0,
    OP_CHECK_LAST = 2'd1,
    OP_SET_FRAME  = 2'd2,
    OP_SET_DIR    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_FRAME = 3'd0,
    CFG_END_FRAME   = 3'd1,
    CFG_STEP_SIZE   = 3'd2,
    CFG_REPEAT_PLAY = 3'd3,
    CFG_FRAME_MASK  = 3'd4
  } cfg_idx_e;

  localparam logic [DirW-1:0] DIR_PAUSE = 2'b00;
  localparam logic [DirW-1:0] DIR_FWD   = 2'b01;
  localparam logic [DirW-1:0] DIR_BACK  = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SEARCH,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic search_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic dir_zero;
    logic range_empty;
    logic search_done;
  } status_t;

endpackage

[rtl/fps_in_if.sv]
`timescale 1ns / 1ps

interface fps_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [fps_pkg::FrameW-1:0]    frame_value;
  logic signed [fps_pkg::DirW-1:0] direction_value;

  modport source (output valid, output opcode, output frame_value,
                  output direction_value, input ready);
  modport sink   (input valid, input opcode, input frame_value,
                  input direction_value, output ready);
endinterface

[rtl/fps_out_if.sv]
`timescale 1ns / 1ps

interface fps_out_if;
  logic                            valid;
  logic                            ready;
  logic [fps_pkg::FrameW-1:0]      current_frame;
  logic signed [fps_pkg::DirW-1:0] play_direction;
  logic                            change_flag;

  modport source (output valid, output current_frame, output play_direction,
                  output change_flag, input ready);
  modport sink   (input valid, input current_frame, input play_direction,
                  input change_flag, output ready);
endinterface

[rtl/fps_ctrl.sv]
`timescale 1ns / 1ps

module fps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fps_pkg::status_t status_i,
  output fps_pkg::cmd_t    cmd_o
);

  fps_pkg::state_e state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            short_item;

  assign out_free = !out_valid_q || out_ready_i;

  // items that need no search go straight to the write
  assign short_item = (status_i.op == fps_pkg::OP_SET_FRAME) ||
                      (status_i.op == fps_pkg::OP_SET_DIR) ||
                      ((status_i.op == fps_pkg::OP_ADVANCE) && status_i.dir_zero) ||
                      status_i.range_empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fps_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fps_pkg::ST_PREP;
      end
      fps_pkg::ST_PREP: begin
        state_d = short_item ? fps_pkg::ST_WRITE : fps_pkg::ST_DIV;
      end
      fps_pkg::ST_DIV: begin
        if (cnt_q == 3'd7) state_d = fps_pkg::ST_SEARCH;
      end
      fps_pkg::ST_SEARCH: begin
        if (status_i.search_done) state_d = fps_pkg::ST_WRITE;
      end
      fps_pkg::ST_WRITE: begin
        if (out_free) state_d = fps_pkg::ST_IDLE;
      end
      default: state_d = fps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    in_ready_o        = (state_q == fps_pkg::ST_IDLE);
    cmd_o.load        = in_ready_o && in_valid_i;
    cmd_o.prep        = (state_q == fps_pkg::ST_PREP);
    cmd_o.div_step    = (state_q == fps_pkg::ST_DIV);
    cmd_o.search_step = (state_q == fps_pkg::ST_SEARCH);
    cmd_o.commit      = (state_q == fps_pkg::ST_WRITE) && out_free;
    cnt_d             = cmd_o.prep ? 3'd0 : (cmd_o.div_step ? cnt_q + 3'd1 : cnt_q);
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fps_pkg::ST_IDLE;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/fps_dp.sv]
`timescale 1ns / 1ps

module fps_dp #(
  parameter int unsigned MaxFrames = fps_pkg::MAX_FRAMES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fps_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [1:0]                       opcode_i,
  input  logic [fps_pkg::FrameW-1:0]       frame_value_i,
  input  logic signed [fps_pkg::DirW-1:0]  direction_value_i,
  input  fps_pkg::cmd_t                    cmd_i,
  output fps_pkg::status_t                 status_o,
  output logic [fps_pkg::FrameW-1:0]       current_frame_o,
  output logic signed [fps_pkg::DirW-1:0]  play_direction_o,
  output logic                             change_flag_o
);

  localparam int unsigned FW = fps_pkg::FrameW;
  localparam int unsigned DW = fps_pkg::DirW;
  localparam int unsigned SW = fps_pkg::StepW;
  localparam int unsigned QW = fps_pkg::DivW;
  localparam int unsigned TW = fps_pkg::TestW;

  // configuration
  logic [FW-1:0]              start_q, end_q;
  logic [SW-1:0]              step_q;
  logic                       repeat_q;
  logic [fps_pkg::MaskW-1:0]  mask_q;

  // sequencer state
  logic [FW-1:0]              frame_q, frame_d;
  logic [DW-1:0]              dir_q, dir_d;

  // item and work registers
  fps_pkg::op_e               op_q;
  logic [FW-1:0]              fv_q;
  logic [DW-1:0]              dv_q;
  logic [QW-1:0]              rem_q, rem_d;
  logic [QW-1:0]              quo_q, quo_d;
  logic signed [TW-1:0]       test_q, test_d;
  logic [FW-1:0]              nf_q, nf_d;
  logic [FW-1:0]              out_frame_q;
  logic [DW-1:0]              out_dir_q;
  logic                       out_flag_q;
  logic                       flag_d;

  logic [SW-1:0]              step_eff;
  logic signed [TW-1:0]       delta;
  logic signed [TW-1:0]       first_s, last_s, cur_s;
  logic signed [TW-1:0]       t1, t2;
  logic [QW-1:0]              dividend;
  logic [QW-1:0]              rem_sh;
  logic                       rem_ge;
  logic                       has_data;

  assign step_eff = (step_q == '0) ? SW'(1) : step_q;
  assign first_s  = $signed({{(TW-FW){1'b0}}, start_q});
  assign last_s   = $signed({{(TW-FW){1'b0}}, end_q});
  assign cur_s    = $signed({{(TW-FW){1'b0}}, frame_q});

  always_comb begin
    unique case (dir_q)
      fps_pkg::DIR_FWD:  delta = $signed({{(TW-SW){1'b0}}, step_eff});
      fps_pkg::DIR_BACK: delta = -$signed({{(TW-SW){1'b0}}, step_eff});
      default:           delta = '0;
    endcase
  end

  assign dividend = QW'(end_q) - QW'(start_q) + QW'(step_eff);

  // one restoring division step: rem_q stays below the step, so the shift fits
  assign rem_sh = {rem_q[QW-2:0], quo_q[QW-1]};
  assign rem_ge = rem_sh >= QW'(step_eff);

  // wrap the candidate (repeat off: to the current frame), then look up its bit
  always_comb begin
    t1 = test_q;
    if (t1 > last_s) t1 = repeat_q ? first_s : cur_s;
    t2 = t1;
    if (t2 < first_s) t2 = repeat_q ? last_s : cur_s;
  end

  assign has_data = (t2[TW-1:FW] == '0) &&
                    ({1'b0, t2[FW-1:0]} < (FW+1)'(MaxFrames)) &&
                    mask_q[t2[FW-1:0]];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    test_d = test_q;
    nf_d   = nf_q;
    if (cmd_i.prep) begin
      rem_d  = '0;
      quo_d  = dividend;
      test_d = cur_s + delta;
      nf_d   = frame_q;
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? rem_sh - QW'(step_eff) : rem_sh;
      quo_d = {quo_q[QW-2:0], rem_ge};
    end else if (cmd_i.search_step && (quo_q != '0)) begin
      // quo_q now counts the tries left
      if (has_data) begin
        nf_d = t2[FW-1:0];
      end else begin
        test_d = t2 + delta;
        quo_d  = quo_q - QW'(1);
      end
    end
  end

  always_comb begin
    frame_d = frame_q;
    dir_d   = dir_q;
    flag_d  = 1'b0;
    unique case (op_q)
      fps_pkg::OP_ADVANCE: begin
        if (dir_q != fps_pkg::DIR_PAUSE) begin
          if (nf_q == frame_q) begin
            if (!repeat_q) begin
              dir_d  = fps_pkg::DIR_PAUSE;
              flag_d = 1'b1;
            end
          end else begin
            // flag a move against the play direction
            flag_d  = (dir_q == fps_pkg::DIR_FWD) ? (nf_q < frame_q) : (nf_q > frame_q);
            frame_d = nf_q;
          end
        end
      end
      fps_pkg::OP_CHECK_LAST: begin
        if (nf_q == frame_q) begin
          dir_d  = fps_pkg::DIR_PAUSE;
          flag_d = 1'b1;
        end
      end
      fps_pkg::OP_SET_FRAME: begin
        frame_d = ({1'b0, fv_q} >= (FW+1)'(MaxFrames)) ? FW'(MaxFrames - 1) : fv_q;
      end
      fps_pkg::OP_SET_DIR: begin
        unique case (dv_q)
          fps_pkg::DIR_PAUSE: dir_d = fps_pkg::DIR_PAUSE;
          fps_pkg::DIR_FWD:   dir_d = fps_pkg::DIR_FWD;
          default:            dir_d = fps_pkg::DIR_BACK;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= FW'(63);
      step_q   <= SW'(1);
      repeat_q <= 1'b0;
      mask_q   <= '1;
      frame_q  <= '0;
      dir_q    <= fps_pkg::DIR_PAUSE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fps_pkg::CFG_START_FRAME: start_q  <= cfg_wdata_i[FW-1:0];
          fps_pkg::CFG_END_FRAME:   end_q    <= cfg_wdata_i[FW-1:0];
          fps_pkg::CFG_STEP_SIZE:   step_q   <= cfg_wdata_i[SW-1:0];
          fps_pkg::CFG_REPEAT_PLAY: repeat_q <= cfg_wdata_i[0];
          fps_pkg::CFG_FRAME_MASK:  mask_q   <= cfg_wdata_i[fps_pkg::MaskW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        frame_q <= frame_d;
        dir_q   <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= fps_pkg::op_e'(opcode_i);
      fv_q <= frame_value_i;
      dv_q <= direction_value_i;
    end
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    test_q <= test_d;
    nf_q   <= nf_d;
    if (cmd_i.commit) begin
      out_frame_q <= frame_d;
      out_dir_q   <= dir_d;
      out_flag_q  <= flag_d;
    end
  end

  assign status_o.op          = op_q;
  assign status_o.dir_zero    = (dir_q == fps_pkg::DIR_PAUSE);
  assign status_o.range_empty = end_q < start_q;
  assign status_o.search_done = (quo_q == '0) || has_data;

  assign current_frame_o  = out_frame_q;
  assign play_direction_o = out_dir_q;
  assign change_flag_o    = out_flag_q;

endmodule

[rtl/frame_playback_sequencer_top.sv]
`timescale 1ns / 1ps

// Channel  Dir  Beat
// in_i     in   opcode, frame_value, direction_value
// out_o    out  current_frame, play_direction, change_flag
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i (write only, no stall)
//
// Set frame, set direction, an advance while paused and any search over an
// empty range (end before start) skip the search and go from the prep state
// straight to the write state. Other advances and check-lasts run a restoring
// divider that sizes the search to at most 64 candidates, then a loop that
// checks one candidate a cycle until one has data or the try count runs out.
// A new beat is taken while a result waits on out_o; the next result holds in
// the write state until out_o is free.
// Reset is asynchronous, active low, and restores the register defaults.
module frame_playback_sequencer_top #(
  parameter int unsigned MaxFrames = fps_pkg::MAX_FRAMES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  fps_in_if.sink                        in_i,
  fps_out_if.source                     out_o
);

  fps_pkg::cmd_t    cmd;
  fps_pkg::status_t status;

  fps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fps_dp #(
    .MaxFrames (MaxFrames)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (in_i.opcode),
    .frame_value_i     (in_i.frame_value),
    .direction_value_i (in_i.direction_value),
    .cmd_i             (cmd),
    .status_o          (status),
    .current_frame_o   (out_o.current_frame),
    .play_direction_o  (out_o.play_direction),
    .change_flag_o     (out_o.change_flag)
  );

  // never overwrite a result that has not been taken
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("result written over a pending beat");

  // one item at a time: no new beat right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("written result not shown");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.play_direction != 2'sb10))
    else $error("play direction out of range");

endmodule

[tb/frame_playback_sequencer_top_tb.sv]
`timescale 1ns / 1ps

module frame_playback_sequencer_top_tb;
  import fps_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int ChunkItems = 40;

  typedef struct packed {
    logic [FrameW-1:0]      frame;
    logic signed [DirW-1:0] dir;
    logic                   flag;
  } frame_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  fps_in_if  in_if ();
  fps_out_if out_if ();

  frame_playback_sequencer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // playback state and registers as the block should hold them
  int            frame_q = 0;
  int            dir_q   = 0;
  int            start_q = 0;
  int            end_q   = 63;
  int            step_q  = 1;
  logic          rep_q   = 1'b0;
  logic [MaskW-1:0] mask_q = '1;

  frame_beat_t frame_beats_due[$];
  int          err_count    = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_left    = 0;
  int          cycle_count  = 0;

  always #5 clk_i = ~clk_i;

  function automatic int seek_frame(int dir);
    int step, tries, probe;
    step = (step_q == 0) ? 1 : step_q;
    if (end_q < start_q) return frame_q;
    tries = (end_q - start_q + step) / step;
    probe = frame_q + dir * step;
    for (int k = 1; k <= tries; k++) begin
      if (probe > end_q) probe = rep_q ? start_q : frame_q;
      if (probe < start_q) probe = rep_q ? end_q : frame_q;
      // frames beyond the frame count never hold data
      if (probe >= 0 && probe < int'(MAX_FRAMES) && mask_q[probe]) return probe;
      probe += dir * step;
    end
    return frame_q;
  endfunction

  function automatic frame_beat_t playback_step(op_e op, logic [FrameW-1:0] fv,
                                                logic [DirW-1:0] dv);
    frame_beat_t beat;
    int          nf;
    logic        flag;
    flag = 1'b0;
    case (op)
      OP_ADVANCE: begin
        if (dir_q != 0) begin
          nf = seek_frame(dir_q);
          if (nf == frame_q) begin
            if (!rep_q) begin
              dir_q = 0;
              flag  = 1'b1;
            end
          end else begin
            // moving against the play direction needs a refresh
            if ((nf - frame_q) * dir_q <= 0) flag = 1'b1;
            frame_q = nf;
          end
        end
      end
      OP_CHECK_LAST: begin
        nf = seek_frame(dir_q);
        if (nf == frame_q) begin
          dir_q = 0;
          flag  = 1'b1;
        end
      end
      OP_SET_FRAME: begin
        frame_q = (int'(fv) >= int'(MAX_FRAMES)) ? int'(MAX_FRAMES) - 1 : int'(fv);
      end
      default: begin
        if (dv == DIR_PAUSE) dir_q = 0;
        else if (dv == DIR_FWD) dir_q = 1;
        else dir_q = -1;
      end
    endcase
    beat.frame = frame_q[FrameW-1:0];
    beat.dir   = dir_q[DirW-1:0];
    beat.flag  = flag;
    return beat;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (frame_beats_due.size() == 0) begin
        $error("result beat with no expectation: frame %0d dir %0d flag %0d",
               out_if.current_frame, out_if.play_direction, out_if.change_flag);
        err_count++;
      end else begin
        want = frame_beats_due.pop_front();
        if (out_if.current_frame !== want.frame) begin
          $error("current_frame: expected %0d, actual %0d", want.frame, out_if.current_frame);
          err_count++;
        end
        if (out_if.play_direction !== want.dir) begin
          $error("play_direction: expected %0d, actual %0d", want.dir, out_if.play_direction);
          err_count++;
        end
        if (out_if.change_flag !== want.flag) begin
          $error("change_flag: expected %0d, actual %0d", want.flag, out_if.change_flag);
          err_count++;
        end
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_beat(input op_e op, input logic [FrameW-1:0] fv,
                           input logic [DirW-1:0] dv);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct && gap < 40) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.opcode          <= op;
    in_if.frame_value     <= fv;
    in_if.direction_value <= dv;
    do @(posedge clk_i); while (!in_if.ready);
    frame_beats_due.push_back(playback_step(op, fv, dv));
  endtask

  // drop valid and hold until every result is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (frame_beats_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_FRAME: start_q = int'(val[5:0]);
      CFG_END_FRAME:   end_q   = int'(val[5:0]);
      CFG_STEP_SIZE:   step_q  = int'(val[6:0]);
      CFG_REPEAT_PLAY: rep_q   = val[0];
      CFG_FRAME_MASK:  mask_q  = val;
      default: ;
    endcase
  endtask

  task automatic test_basic_ops();
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_CHECK_LAST, 6'd5, DIR_FWD);
    send_beat(OP_SET_FRAME, 6'd63, DIR_BACK);
    send_beat(OP_SET_DIR, 6'd0, DIR_FWD);
    // forward past the last frame with repeat off: pause
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_SET_DIR, 6'd63, DIR_BACK);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_SET_FRAME, 6'd0, DIR_PAUSE);
    // pattern 2'b10 counts as backward
    send_beat(OP_SET_DIR, 6'd0, 2'b10);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_SET_DIR, 6'd0, DIR_FWD);
    send_beat(OP_CHECK_LAST, 6'd0, DIR_PAUSE);
    wait_idle();
  endtask

  task automatic test_wrap_and_mask();
    write_reg(CFG_START_FRAME, 64'd5);
    write_reg(CFG_END_FRAME, 64'd40);
    write_reg(CFG_STEP_SIZE, 64'd3);
    write_reg(CFG_REPEAT_PLAY, 64'd1);
    write_reg(CFG_FRAME_MASK, 64'hA5A5_0F0F_3C3C_FFF0);
    send_beat(OP_SET_FRAME, 6'd38, DIR_PAUSE);
    send_beat(OP_SET_DIR, 6'd0, DIR_FWD);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_SET_DIR, 6'd0, DIR_BACK);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_CHECK_LAST, 6'd0, DIR_PAUSE);
    wait_idle();
  endtask

  task automatic test_corner_setup();
    write_reg(CFG_STEP_SIZE, 64'd0);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    wait_idle();
    // end before start: nothing to search
    write_reg(CFG_START_FRAME, 64'd10);
    write_reg(CFG_END_FRAME, 64'd2);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    send_beat(OP_CHECK_LAST, 6'd0, DIR_PAUSE);
    wait_idle();
    write_reg(CFG_START_FRAME, 64'd0);
    write_reg(CFG_END_FRAME, 64'd63);
    write_reg(CFG_STEP_SIZE, 64'd127);
    write_reg(CFG_REPEAT_PLAY, 64'd0);
    write_reg(CFG_FRAME_MASK, 64'd0);
    send_beat(OP_SET_DIR, 6'd0, DIR_FWD);
    send_beat(OP_ADVANCE, 6'd0, DIR_PAUSE);
    wait_idle();
  endtask

  task automatic pick_range_setup();
    int               sel;
    int               first;
    int               last;
    logic [MaskW-1:0] mask;
    sel = $urandom_range(9);
    first = (sel == 0) ? 0 : (sel == 1) ? 63 : $urandom_range(63);
    sel = $urandom_range(9);
    if (sel == 0) last = 0;
    else if (sel == 1) last = 63;
    else if (sel < 8) last = first + $urandom_range(63 - first);
    else last = $urandom_range(63);
    write_reg(CFG_START_FRAME, 64'(first));
    write_reg(CFG_END_FRAME, 64'(last));
    sel = $urandom_range(9);
    case (sel)
      0: write_reg(CFG_STEP_SIZE, 64'd0);
      1: write_reg(CFG_STEP_SIZE, 64'd127);
      2: write_reg(CFG_STEP_SIZE, 64'd64);
      3: write_reg(CFG_STEP_SIZE, 64'($urandom_range(127)));
      default: write_reg(CFG_STEP_SIZE, 64'($urandom_range(6, 1)));
    endcase
    write_reg(CFG_REPEAT_PLAY, 64'($urandom_range(1)));
    sel = $urandom_range(9);
    case (sel)
      0: mask = '1;
      1: mask = '0;
      2: mask = {$urandom, $urandom};
      3: mask = 64'd1 << $urandom_range(63);
      4, 5: mask = {$urandom, $urandom} & {$urandom, $urandom};
      default: mask = {$urandom, $urandom} | {$urandom, $urandom};
    endcase
    write_reg(CFG_FRAME_MASK, mask);
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int chunks);
    int               sel;
    logic [FrameW-1:0] fv;
    logic [DirW-1:0]   dv;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int c = 0; c < chunks; c++) begin
      wait_idle();
      pick_range_setup();
      for (int i = 0; i < ChunkItems; i++) begin
        sel = $urandom_range(99);
        fv  = FrameW'($urandom_range(63));
        dv  = DirW'($urandom_range(3));
        if (sel < 50) begin
          send_beat(OP_ADVANCE, fv, dv);
        end else if (sel < 62) begin
          send_beat(OP_CHECK_LAST, fv, dv);
        end else if (sel < 78) begin
          // mostly land inside the playback range
          if (start_q <= end_q && $urandom_range(9) < 7)
            fv = FrameW'($urandom_range(end_q, start_q));
          send_beat(OP_SET_FRAME, fv, dv);
        end else begin
          send_beat(OP_SET_DIR, fv, dv);
        end
      end
    end
    wait_idle();
  endtask

  // stall the output long enough that the input backs up
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(CFG_START_FRAME, 64'd0);
    write_reg(CFG_END_FRAME, 64'd63);
    write_reg(CFG_STEP_SIZE, 64'd5);
    write_reg(CFG_REPEAT_PLAY, 64'd1);
    write_reg(CFG_FRAME_MASK, {$urandom, $urandom});
    send_beat(OP_SET_DIR, 6'd0, DIR_FWD);
    @(negedge clk_i);
    hold_left = 400;
    for (int i = 0; i < 12; i++) begin
      send_beat(i % 3 == 2 ? OP_CHECK_LAST : OP_ADVANCE, 6'($urandom_range(63)),
                DIR_FWD);
    end
    wait_idle();
  endtask

  initial begin
    int guard;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_START_FRAME;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.opcode          = OP_ADVANCE;
    in_if.frame_value     = '0;
    in_if.direction_value = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_basic_ops();
    test_wrap_and_mask();
    test_corner_setup();
    test_random_phase(12, 77, 15);
    test_random_phase(77, 12, 15);
    test_random_phase(0, 0, 15);
    test_backpressure();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    guard = 0;
    while (frame_beats_due.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (frame_beats_due.size() != 0) begin
      $error("%0d expected result beats never arrived", frame_beats_due.size());
      err_count++;
    end
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[frame_playback_sequencer_top.f]
rtl/fps_pkg.sv
rtl/fps_in_if.sv
rtl/fps_out_if.sv
rtl/fps_ctrl.sv
rtl/fps_dp.sv
rtl/frame_playback_sequencer_top.sv
tb/frame_playback_sequencer_top_tb.sv
